### hdl/arp_cache_responder_macros.svh
// Assertion helpers used by the engine RTL.
`ifndef ARP_CACHE_RESPONDER_MACROS_SVH
`define ARP_CACHE_RESPONDER_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ARPC_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ARPC_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

   localparam int ENTRIES = 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam logic [7:0]  AGE_LIMIT  = 8'hff;
   localparam logic [15:0] OP_REQUEST = 16'd1;
   localparam logic [15:0] OP_REPLY   = 16'd2;
   localparam logic        MODE_LOOKUP = 1'b0;
   localparam logic        MODE_PACKET = 1'b1;

   // APB address: register index sits above the byte offset
   localparam int   CSR_ADDR_W = 3;
   localparam logic REG_MY_IP  = 1'b0;

   typedef struct packed {
      logic        mode;
      logic [31:0] peer_ip;
      logic [31:0] target_ip;
      logic [47:0] peer_mac;
      logic [15:0] arp_op;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [47:0] found_mac;
      logic        need_request;
      logic        for_us;
      logic        need_reply;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [7:0]  age;
   } ent_type;

   localparam int ENT_W = $bits(ent_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      ent_type          wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } ram_ctl_type;

endpackage

`default_nettype wire

### hdl/arpc_ram.sv
`default_nettype none

module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hdl/arpc_csr.sv
`default_nettype none

module arpc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [arpc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready,
   output logic      [31:0]                    my_ip
);

   import arpc_pkg::*;

   logic [31:0] my_ip_ff;
   logic [31:0] my_ip_in;
   logic        wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_MY_IP);

   always_comb begin
      my_ip_in = wr_hit ? pwdata : my_ip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_ip_ff <= '0;
      end else begin
         my_ip_ff <= my_ip_in;
      end
   end

   assign prdata = (paddr[2] == REG_MY_IP) ? my_ip_ff : 32'd0;
   assign my_ip  = my_ip_ff;

endmodule

`default_nettype wire

### hdl/arpc_engine.sv
`default_nettype none

`include "arp_cache_responder_macros.svh"

module arpc_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [31:0]           my_ip,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire arpc_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output arpc_pkg::rsp_type          rsp_data,
   output arpc_pkg::ram_ctl_type      ram_ctl,
   input  wire arpc_pkg::ent_type     ram_rdata
);

   import arpc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               matched_ff, matched_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [47:0]        match_mac_ff, match_mac_in;
   logic [7:0]         least_ff, least_in;
   logic [IDX_W-1:0]   victim_ff, victim_in;
   logic [7:0]         age_top_ff, age_top_in;
   logic [ENTRIES-1:0] ent_vld_ff, ent_vld_in;
   logic [ENTRIES-1:0] age_vld_ff, age_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic        accept;
   logic        issue;
   logic [31:0] cur_ip;
   logic [47:0] cur_mac;
   logic [7:0]  cur_age;
   logic        for_us;
   logic        learn;
   logic        lookup;
   logic [IDX_W-1:0] slot;
   logic [7:0]  age_next;
   logic        wrap;
   logic        finish_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign issue     = (state_ff == ST_SCAN) && (scan_idx_ff < CNT_W'(ENTRIES));

   // cleared entries read as zero
   assign cur_ip  = ent_vld_ff[cmp_idx_ff] ? ram_rdata.ip  : 32'd0;
   assign cur_mac = ent_vld_ff[cmp_idx_ff] ? ram_rdata.mac : 48'd0;
   assign cur_age = age_vld_ff[cmp_idx_ff] ? ram_rdata.age : 8'd0;

   assign lookup    = (req_ff.mode == MODE_LOOKUP);
   assign for_us    = (req_ff.mode == MODE_PACKET) && (req_ff.target_ip == my_ip);
   assign learn     = for_us && ((req_ff.arp_op == OP_REQUEST) || (req_ff.arp_op == OP_REPLY));
   assign slot      = matched_ff ? match_idx_ff : victim_ff;
   assign age_next  = age_top_ff + 8'd1;
   assign wrap      = (age_next == AGE_LIMIT);
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ram_ctl.we        = finish_go && learn;
      ram_ctl.waddr     = slot;
      ram_ctl.wdata.ip  = req_ff.peer_ip;
      ram_ctl.wdata.mac = req_ff.peer_mac;
      ram_ctl.wdata.age = age_next;
      ram_ctl.re        = accept || issue;
      ram_ctl.raddr     = accept ? IDX_W'(0) : scan_idx_ff[IDX_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      matched_in   = matched_ff;
      match_idx_in = match_idx_ff;
      match_mac_in = match_mac_ff;
      least_in     = least_ff;
      victim_in    = victim_ff;
      age_top_in   = age_top_ff;
      ent_vld_in   = ent_vld_ff;
      age_vld_in   = age_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      // compare stage: first IP match wins, victim is lowest index of least age
      if (cmp_vld_ff) begin
         if (!matched_ff && (cur_ip == req_ff.peer_ip)) begin
            matched_in   = 1'b1;
            match_idx_in = cmp_idx_ff;
            match_mac_in = cur_mac;
         end
         if (cur_age < least_ff) begin
            least_in  = cur_age;
            victim_in = cmp_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_data;
               scan_idx_in = CNT_W'(1);
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = IDX_W'(0);
               matched_in  = 1'b0;
               least_in    = AGE_LIMIT;
               victim_in   = IDX_W'(0);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[IDX_W-1:0];
            end
            if (cmp_vld_ff && (cmp_idx_ff == IDX_W'(ENTRIES - 1))) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in        = 1'b1;
               rsp_in.hit          = lookup && matched_ff;
               rsp_in.found_mac    = (lookup && matched_ff) ? match_mac_ff : 48'd0;
               rsp_in.need_request = lookup && !matched_ff;
               rsp_in.for_us       = for_us;
               rsp_in.need_reply   = for_us && (req_ff.arp_op == OP_REQUEST);
               if (learn) begin
                  ent_vld_in[slot] = 1'b1;
                  if (wrap) begin
                     age_vld_in = '0;
                     age_top_in = 8'd0;
                  end else begin
                     age_vld_in[slot] = 1'b1;
                     age_top_in       = age_next;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         age_top_ff   <= 8'd0;
         ent_vld_ff   <= '0;
         age_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         age_top_ff   <= age_top_in;
         ent_vld_ff   <= ent_vld_in;
         age_vld_ff   <= age_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      matched_ff   <= matched_in;
      match_idx_ff <= match_idx_in;
      match_mac_ff <= match_mac_in;
      least_ff     <= least_in;
      victim_ff    <= victim_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ARPC_ASSERT_ALWAYS(a_write_in_finish, clock, reset, !ram_ctl.we || (state_ff == ST_FINISH), "table written outside finish")
   `ARPC_ASSERT_ALWAYS(a_age_top_below_limit, clock, reset, age_top_ff != AGE_LIMIT, "age counter holds the limit")
   `ARPC_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, cmp_vld_ff && (cmp_idx_ff == IDX_W'(0)), "accepted request did not start scan")
   `ARPC_ASSERT_ALWAYS(a_rsp_from_finish, clock, reset, !$rose(rsp_valid_ff) || $past(state_ff == ST_FINISH), "response raised outside finish")
   `ARPC_ASSERT_ALWAYS(a_no_read_while_write, clock, reset, !(ram_ctl.we && ram_ctl.re), "table read and written together")

endmodule

`default_nettype wire

### hdl/arp_cache_responder.sv
// ARP cache responder: an IPv4-to-MAC table with age-based replacement.
// Request channel (req_valid/req_ready/req_data): mode 0 looks up peer_ip and
// answers hit and found_mac, or need_request on a miss. Mode 1 carries a
// received ARP packet; when target_ip equals my_ip it sets for_us, and a
// request or reply refreshes the sender's entry or replaces the least-aged
// one, a request also raising need_reply.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
// request, in order.
// Each request scans the table through the single read port of the entry
// memory, one entry a cycle, then writes back; the next request is accepted
// only once the engine is back in idle after raising the response.
// my_ip is written over the APB port at byte address 0; pready is always high.
// Reset empties the table at once through per-entry valid bits and clears the
// age counter and my_ip; no clearing pass is needed.
// A stalled response waits in its output register; the next request is still
// accepted and scanned, and its response holds in finish until the register frees.
`default_nettype none

module arp_cache_responder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire arpc_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output arpc_pkg::rsp_type                    rsp_data,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [arpc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);

   import arpc_pkg::*;

   logic [31:0]  my_ip;
   ram_ctl_type  ram_ctl;
   logic [ENT_W-1:0] ram_rdata;

   // hold the own address for the packet filter
   arpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .my_ip   (my_ip)
   );

   // entry memory: IP, MAC and age of each entry in one word
   arpc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .re    (ram_ctl.re),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

   // scan, pick the entry, write back and form the response
   arpc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .my_ip     (my_ip),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ram_ctl   (ram_ctl),
      .ram_rdata (ram_rdata)
   );

endmodule

`default_nettype wire
